/* hdl/two_level_cache_hierarchy_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the two-level cache hierarchy unit.
// Each macro checks on the rising edge of clk and is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_CACHE_HIERARCHY_UNIT_ASSERT_SVH
`define TWO_LEVEL_CACHE_HIERARCHY_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TLCH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TLCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tlch_pkg.sv */
// ---------------------------------------------------------------------------
// tlch_pkg
// Shared types and constants of the two-level cache hierarchy unit.
// ---------------------------------------------------------------------------
package tlch_pkg;

    // Geometry.
    localparam int L1_SETS    = 16;
    localparam int L1_WAYS    = 2;
    localparam int L2_SETS    = 64;
    localparam int L2_WAYS    = 4;
    localparam int LINE_WORDS = 8;
    localparam int MEM_WORDS  = 4096;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int ADDR_W = 14;
    localparam int DATA_W = 32;
    localparam int PEN_W  = 8;

    // Derived address split.
    localparam int WORD_AW   = ADDR_W - 2;
    localparam int OFF_W     = $clog2(LINE_WORDS);
    localparam int LINE_W    = WORD_AW - OFF_W;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int L1_SET_W  = $clog2(L1_SETS);
    localparam int L1_WAY_W  = $clog2(L1_WAYS);
    localparam int L1_TAG_W  = LINE_W - L1_SET_W;
    localparam int L1_SLOTS  = L1_SETS * L1_WAYS;
    localparam int L1_SLOT_W = L1_SET_W + L1_WAY_W;
    localparam int L1_DAT_AW = L1_SLOT_W + OFF_W;
    localparam int L2_SET_W  = $clog2(L2_SETS);
    localparam int L2_WAY_W  = $clog2(L2_WAYS);
    localparam int L2_TAG_W  = LINE_W - L2_SET_W;
    localparam int L2_DAT_AW = L2_SET_W + L2_WAY_W + OFF_W;

    // Operation codes. The reserved code behaves as idle.
    localparam logic [OP_W-1:0] OP_IDLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BYPASS = 2'd0;
    localparam logic [1:0] CFG_L1_PEN = 2'd1;
    localparam logic [1:0] CFG_L2_PEN = 2'd2;

    // Reset values of the penalty registers.
    localparam logic [PEN_W-1:0] L1_PEN_RESET = 8'd2;
    localparam logic [PEN_W-1:0] L2_PEN_RESET = 8'd10;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] store_value;
    } req_t;

    typedef struct packed {
        logic              done_res;
        logic [DATA_W-1:0] rd_word;
    } res_t;

    // Per-way L2 bookkeeping kept in the row memory.
    typedef struct packed {
        logic [L2_TAG_W-1:0] tag;
        logic                dirty;
        logic [L2_WAY_W-1:0] age;
    } l2_meta_t;

    typedef l2_meta_t [L2_WAYS-1:0] l2_row_t;

endpackage

/* hdl/two_level_cache_hierarchy_unit.sv */
// ---------------------------------------------------------------------------
// two_level_cache_hierarchy_unit
// Word access port over an L1 and an inclusive L2 write-back cache with
// age-counter LRU and a main memory behind them.
// ---------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   start / busy              req  (operation, byte_address, store_value)
//  result    res_strobe (one cycle)    res  (done_res, rd_word)
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  After reset the unit clears all 4096 words of main memory, one word a cycle,
//  with busy high; configuration writes are taken during that pass.
//  An idle access or a write hit is answered from the lookup state, a read hit
//  or bypass read from the read state after it. An L1 miss answered by L2 and
//  an L2 refill end in an eight-word line copy through the single-write data memories.
//  The result strobe is high for one cycle; the receiver cannot stall it.
// ---------------------------------------------------------------------------
`include "two_level_cache_hierarchy_unit_assert.svh"

module two_level_cache_hierarchy_unit
    import tlch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             res_strobe,
    output res_t             res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [PEN_W-1:0] cfg_data
);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_LOOK1 = 11'b000_0000_0100,
        ST_RD1   = 11'b000_0000_1000,
        ST_RDMEM = 11'b000_0001_0000,
        ST_L2REQ = 11'b000_0010_0000,
        ST_L2CHK = 11'b000_0100_0000,
        ST_VREQ  = 11'b000_1000_0000,
        ST_VCHK  = 11'b001_0000_0000,
        ST_COPY1 = 11'b010_0000_0000,
        ST_COPY2 = 11'b100_0000_0000
    } state_t;

    // Control registers.
    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   clr_reg, clr_next;
    logic [OFF_W:0]      cnt_reg, cnt_next;
    logic [PEN_W-1:0]    l1_wait_reg, l1_wait_next;
    logic [PEN_W-1:0]    l2_wait_reg, l2_wait_next;
    logic                l2fail_reg, l2fail_next;
    logic [L2_WAY_W-1:0] s2way_reg, s2way_next;
    logic [L2_WAY_W-1:0] twy_reg, twy_next;
    logic [L1_WAY_W-1:0] l1way_reg, l1way_next;
    logic [LINE_W-1:0]   vln_reg, vln_next;
    logic                wb_reg, wb_next;
    logic                l1sel_reg, l1sel_next;
    logic                strobe_reg, strobe_next;
    res_t                res_reg, res_next;
    logic                bypass_reg;
    logic [PEN_W-1:0]    l1_pen_reg, l2_pen_reg;

    // Captured request.
    logic [OP_W-1:0]   op_reg;
    logic [LINE_W-1:0] line_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [DATA_W-1:0] wdata_reg;

    // Bookkeeping in flip-flops.
    logic [L1_SLOTS-1:0] l1_valid_reg;
    logic [L1_TAG_W-1:0] l1_tag_reg   [L1_SLOTS];
    logic                l1_dirty_reg [L1_SLOTS];
    logic [L1_WAY_W-1:0] l1_age_reg   [L1_SLOTS];
    logic [L2_WAYS-1:0]  l2_valid_reg [L2_SETS];
    logic [L2_WAYS-1:0]  row_valid_q;

    // Memories.
    l2_row_t           l2_row_mem  [L2_SETS];
    logic [DATA_W-1:0] l1_data_mem [L1_SLOTS*LINE_WORDS];
    logic [DATA_W-1:0] l2_data_mem [L2_SETS*L2_WAYS*LINE_WORDS];
    logic [DATA_W-1:0] main_mem    [MEM_WORDS];
    l2_row_t           row_q;
    logic [DATA_W-1:0] l1_q, l2_q, mem_q;

    // Memory port controls.
    logic                row_we;
    logic [L2_SET_W-1:0] row_wa, row_ra;
    l2_row_t             row_wd;
    logic                l1d_we;
    logic [L1_DAT_AW-1:0] l1d_wa, l1d_ra;
    logic [DATA_W-1:0]   l1d_wd;
    logic                l2d_we;
    logic [L2_DAT_AW-1:0] l2d_wa, l2d_ra;
    logic [DATA_W-1:0]   l2d_wd;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_wa, mem_ra;
    logic [DATA_W-1:0]   mem_wd;

    // Flip-flop bookkeeping updates.
    logic l1_touch_en, l1_install_en, l1_inval_en, l2_valid_en;

    // Address split of the current access.
    logic                accept;
    logic                is_rw, is_wr;
    logic [WORD_AW-1:0]  word_addr;
    logic [L1_SET_W-1:0] set1;
    logic [L1_TAG_W-1:0] tag1;
    logic [L2_SET_W-1:0] set2;
    logic [L2_TAG_W-1:0] tag2;
    logic [OFF_W-1:0]    rc, wc;
    logic                cnt_wr;

    // L1 search results.
    logic                hit1, vic1_found;
    logic [L1_WAY_W-1:0] hit1_way, vic1_way;
    logic [L1_SLOT_W-1:0] slot1;
    // L1 search for the L2 victim line.
    logic [LINE_W-1:0]   vln2;
    logic [L1_SET_W-1:0] vset1;
    logic [L1_TAG_W-1:0] vtag1;
    logic                hitv1;
    logic [L1_WAY_W-1:0] hitv1_way;
    logic [L1_SLOT_W-1:0] slotv1;
    // L2 row search results.
    logic [L2_TAG_W-1:0] srch_tag;
    logic [L2_WAYS-1:0]  srch_valid;
    logic                hit2, vic2_found;
    logic [L2_WAY_W-1:0] hit2_way, vic2_way;
    l2_row_t             row_touch, row_inst, row_vdirty;
    logic [L2_WAY_W-1:0] cur2;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_strobe = strobe_reg;
    assign res       = res_reg;

    assign is_rw     = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign is_wr     = (op_reg == OP_WRITE);
    assign word_addr = {line_reg, off_reg};
    assign set1      = line_reg[L1_SET_W-1:0];
    assign tag1      = line_reg[LINE_W-1:L1_SET_W];
    assign set2      = line_reg[L2_SET_W-1:0];
    assign tag2      = line_reg[LINE_W-1:L2_SET_W];
    assign rc        = cnt_reg[OFF_W-1:0];
    assign wc        = cnt_reg[OFF_W-1:0] - 1'b1;
    assign cnt_wr    = (cnt_reg != '0);

    // Search the L1 set of the current line and pick its victim way.
    always_comb
    begin
        hit1       = 1'b0;
        hit1_way   = '0;
        vic1_found = 1'b0;
        vic1_way   = '0;
        slot1      = '0;
        for (int w = 0; w < L1_WAYS; w++)
        begin
            slot1 = {set1, L1_WAY_W'(w)};
            if (l1_valid_reg[slot1] && (l1_tag_reg[slot1] == tag1) && !hit1)
            begin
                hit1     = 1'b1;
                hit1_way = L1_WAY_W'(w);
            end
            if ((!l1_valid_reg[slot1] || (l1_age_reg[slot1] == '0)) && !vic1_found)
            begin
                vic1_found = 1'b1;
                vic1_way   = L1_WAY_W'(w);
            end
        end
    end

    // Search the L2 row that was read last; its valid bits were read with it.
    assign srch_tag   = (state_reg == ST_VCHK) ? vln_reg[LINE_W-1:L2_SET_W] : tag2;
    assign srch_valid = row_valid_q;

    always_comb
    begin
        hit2       = 1'b0;
        hit2_way   = '0;
        vic2_found = 1'b0;
        vic2_way   = '0;
        for (int w = 0; w < L2_WAYS; w++)
        begin
            if (srch_valid[w] && (row_q[w].tag == srch_tag) && !hit2)
            begin
                hit2     = 1'b1;
                hit2_way = L2_WAY_W'(w);
            end
            if ((!srch_valid[w] || (row_q[w].age == '0)) && !vic2_found)
            begin
                vic2_found = 1'b1;
                vic2_way   = L2_WAY_W'(w);
            end
        end
    end

    // Row images for an L2 hit, an L2 install and a victim marked dirty.
    assign cur2 = row_q[hit2_way].age;

    always_comb
    begin
        row_touch = row_q;
        for (int w = 0; w < L2_WAYS; w++)
        begin
            if (srch_valid[w] && (row_q[w].age > cur2))
            begin
                row_touch[w].age = row_q[w].age - 1'b1;
            end
        end
        row_touch[hit2_way].age   = L2_WAY_W'(L2_WAYS - 1);
        row_touch[hit2_way].dirty = row_q[hit2_way].dirty | is_wr;

        row_inst = row_q;
        row_inst[vic2_way].tag   = tag2;
        row_inst[vic2_way].dirty = 1'b0;
        row_inst[vic2_way].age   = '0;

        row_vdirty = row_q;
        row_vdirty[hit2_way].dirty = 1'b1;
    end

    // Look up the L2 victim line in L1 so its copy can be merged and dropped.
    assign vln2  = {row_q[vic2_way].tag, set2};
    assign vset1 = vln2[L1_SET_W-1:0];
    assign vtag1 = vln2[LINE_W-1:L1_SET_W];

    always_comb
    begin
        hitv1     = 1'b0;
        hitv1_way = '0;
        slotv1    = '0;
        for (int w = 0; w < L1_WAYS; w++)
        begin
            slotv1 = {vset1, L1_WAY_W'(w)};
            if (l1_valid_reg[slotv1] && (l1_tag_reg[slotv1] == vtag1) && !hitv1)
            begin
                hitv1     = 1'b1;
                hitv1_way = L1_WAY_W'(w);
            end
        end
    end

    // Sequencer: next state, result and memory port selection.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        l1_wait_next  = l1_wait_reg;
        l2_wait_next  = l2_wait_reg;
        l2fail_next   = l2fail_reg;
        s2way_next    = s2way_reg;
        twy_next      = twy_reg;
        l1way_next    = l1way_reg;
        vln_next      = vln_reg;
        wb_next       = wb_reg;
        l1sel_next    = l1sel_reg;
        strobe_next   = 1'b0;
        res_next      = res_reg;

        l1_touch_en   = 1'b0;
        l1_install_en = 1'b0;
        l1_inval_en   = 1'b0;
        l2_valid_en   = 1'b0;

        row_we = 1'b0;
        row_wa = set2;
        row_wd = row_touch;
        row_ra = set2;

        l1d_we = 1'b0;
        l1d_wa = {set1, hit1_way, off_reg};
        l1d_wd = wdata_reg;
        l1d_ra = {set1, hit1_way, off_reg};

        l2d_we = 1'b0;
        l2d_wa = {set2, hit2_way, off_reg};
        l2d_wd = wdata_reg;
        l2d_ra = {set2, s2way_reg, rc};

        mem_we = 1'b0;
        mem_wa = word_addr[MEM_AW-1:0];
        mem_wd = wdata_reg;
        mem_ra = word_addr[MEM_AW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MEM_AW'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK1;
                end
            end

            ST_LOOK1:
            begin
                if (!is_rw)
                begin
                    strobe_next       = 1'b1;
                    res_next.done_res = 1'b1;
                    res_next.rd_word  = '0;
                    state_next        = ST_IDLE;
                end
                else if (bypass_reg)
                begin
                    if (is_wr)
                    begin
                        mem_we            = 1'b1;
                        strobe_next       = 1'b1;
                        res_next.done_res = 1'b1;
                        res_next.rd_word  = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RDMEM;
                    end
                end
                else if (l1_wait_reg != '0)
                begin
                    l1_wait_next = l1_wait_reg - 1'b1;
                    state_next   = ST_L2REQ;
                end
                else if (hit1)
                begin
                    l1_touch_en = 1'b1;
                    if (is_wr)
                    begin
                        l1d_we            = 1'b1;
                        strobe_next       = 1'b1;
                        res_next.done_res = 1'b1;
                        res_next.rd_word  = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD1;
                    end
                end
                else
                begin
                    l1_wait_next = l1_pen_reg - 1'b1;
                    state_next   = ST_L2REQ;
                end
            end

            ST_RD1:
            begin
                strobe_next       = 1'b1;
                res_next.done_res = 1'b1;
                res_next.rd_word  = l1_q;
                state_next        = ST_IDLE;
            end

            ST_RDMEM:
            begin
                strobe_next       = 1'b1;
                res_next.done_res = 1'b1;
                res_next.rd_word  = mem_q;
                state_next        = ST_IDLE;
            end

            ST_L2REQ:
            begin
                // The row read is issued here either way: the refill needs it too.
                l2fail_next = (l2_wait_reg != '0);
                if (l2_wait_reg != '0)
                begin
                    l2_wait_next = l2_wait_reg - 1'b1;
                end
                state_next = ST_L2CHK;
            end

            ST_L2CHK:
            begin
                if (!l2fail_reg && hit2)
                begin
                    // L2 hit: update ages, store a written word, then refill L1 if it misses the line.
                    row_we = 1'b1;
                    row_wd = row_touch;
                    l2d_we = is_wr;
                    if (hit1)
                    begin
                        strobe_next       = 1'b1;
                        res_next.done_res = 1'b0;
                        res_next.rd_word  = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        l1_install_en = 1'b1;
                        s2way_next    = hit2_way;
                        l1way_next    = vic1_way;
                        vln_next      = {l1_tag_reg[{set1, vic1_way}], set1};
                        cnt_next      = '0;
                        wb_next       = 1'b0;
                        if (l1_valid_reg[{set1, vic1_way}] && l1_dirty_reg[{set1, vic1_way}])
                        begin
                            state_next = ST_VREQ;
                        end
                        else
                        begin
                            state_next = ST_COPY1;
                        end
                    end
                end
                else
                begin
                    if (!l2fail_reg)
                    begin
                        l2_wait_next = l2_pen_reg - 1'b1;
                    end
                    if (hit2)
                    begin
                        strobe_next       = 1'b1;
                        res_next.done_res = 1'b0;
                        res_next.rd_word  = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        // Refill L2 from memory over the chosen victim way.
                        row_we      = 1'b1;
                        row_wd      = row_inst;
                        l2_valid_en = 1'b1;
                        s2way_next  = vic2_way;
                        vln_next    = vln2;
                        l1way_next  = hitv1_way;
                        cnt_next    = '0;
                        if (srch_valid[vic2_way])
                        begin
                            l1_inval_en = hitv1;
                            l1sel_next  = hitv1 && l1_dirty_reg[{vset1, hitv1_way}];
                            wb_next     = row_q[vic2_way].dirty ||
                                          (hitv1 && l1_dirty_reg[{vset1, hitv1_way}]);
                        end
                        else
                        begin
                            l1sel_next = 1'b0;
                            wb_next    = 1'b0;
                        end
                        state_next = ST_COPY2;
                    end
                end
            end

            ST_VREQ:
            begin
                row_ra     = vln_reg[L2_SET_W-1:0];
                state_next = ST_VCHK;
            end

            ST_VCHK:
            begin
                // Find the dirty L1 victim in L2 and mark its line dirty.
                row_wa   = vln_reg[L2_SET_W-1:0];
                row_wd   = row_vdirty;
                row_we   = hit2;
                wb_next  = hit2;
                twy_next = hit2_way;
                state_next = ST_COPY1;
            end

            ST_COPY1:
            begin
                // Word rc is read from both levels; word wc is written.
                l2d_ra = {set2, s2way_reg, rc};
                l1d_ra = {set1, l1way_reg, rc};
                l1d_we = cnt_wr;
                l1d_wa = {set1, l1way_reg, wc};
                l1d_wd = l2_q;
                l2d_we = cnt_wr && wb_reg;
                l2d_wa = {vln_reg[L2_SET_W-1:0], twy_reg, wc};
                l2d_wd = l1_q;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (OFF_W+1)'(LINE_WORDS))
                begin
                    strobe_next       = 1'b1;
                    res_next.done_res = 1'b0;
                    res_next.rd_word  = '0;
                    state_next        = ST_IDLE;
                end
            end

            ST_COPY2:
            begin
                mem_ra = MEM_AW'({line_reg, rc});
                l2d_ra = {set2, s2way_reg, rc};
                l1d_ra = {vln_reg[L1_SET_W-1:0], l1way_reg, rc};
                l2d_we = cnt_wr;
                l2d_wa = {set2, s2way_reg, wc};
                l2d_wd = mem_q;
                mem_we = cnt_wr && wb_reg;
                mem_wa = MEM_AW'({vln_reg, wc});
                mem_wd = l1sel_reg ? l1_q : l2_q;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (OFF_W+1)'(LINE_WORDS))
                begin
                    strobe_next       = 1'b1;
                    res_next.done_res = 1'b0;
                    res_next.rd_word  = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            l1_wait_reg <= '0;
            l2_wait_reg <= '0;
            l2fail_reg  <= 1'b0;
            wb_reg      <= 1'b0;
            l1sel_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
            bypass_reg  <= 1'b0;
            l1_pen_reg  <= L1_PEN_RESET;
            l2_pen_reg  <= L2_PEN_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            l1_wait_reg <= l1_wait_next;
            l2_wait_reg <= l2_wait_next;
            l2fail_reg  <= l2fail_next;
            wb_reg      <= wb_next;
            l1sel_reg   <= l1sel_next;
            strobe_reg  <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BYPASS: bypass_reg <= cfg_data[0];
                    CFG_L1_PEN: l1_pen_reg <= cfg_data;
                    CFG_L2_PEN: l2_pen_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        s2way_reg <= s2way_next;
        twy_reg   <= twy_next;
        l1way_reg <= l1way_next;
        vln_reg   <= vln_next;
        if (accept)
        begin
            op_reg    <= req.operation;
            line_reg  <= req.byte_address[ADDR_W-1:2+OFF_W];
            off_reg   <= req.byte_address[2+OFF_W-1:2];
            wdata_reg <= req.store_value;
        end
    end

    // Valid bits of both levels; the L2 valid bits of a set are read with its row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= '0;
            row_valid_q  <= '0;
            for (int s = 0; s < L2_SETS; s++)
            begin
                l2_valid_reg[s] <= '0;
            end
        end
        else
        begin
            row_valid_q <= l2_valid_reg[row_ra];
            if (l1_install_en)
            begin
                l1_valid_reg[{set1, vic1_way}] <= 1'b1;
            end
            if (l1_inval_en)
            begin
                l1_valid_reg[{vset1, hitv1_way}] <= 1'b0;
            end
            if (l2_valid_en)
            begin
                l2_valid_reg[set2][vic2_way] <= 1'b1;
            end
        end
    end

    // L1 tags, dirty bits and ages.
    always_ff @(posedge clk)
    begin
        if (l1_touch_en)
        begin
            for (int w = 0; w < L1_WAYS; w++)
            begin
                if (l1_valid_reg[{set1, L1_WAY_W'(w)}] &&
                    (l1_age_reg[{set1, L1_WAY_W'(w)}] > l1_age_reg[{set1, hit1_way}]))
                begin
                    l1_age_reg[{set1, L1_WAY_W'(w)}] <=
                        l1_age_reg[{set1, L1_WAY_W'(w)}] - 1'b1;
                end
            end
            l1_age_reg[{set1, hit1_way}] <= L1_WAY_W'(L1_WAYS - 1);
            if (is_wr)
            begin
                l1_dirty_reg[{set1, hit1_way}] <= 1'b1;
            end
        end
        if (l1_install_en)
        begin
            l1_tag_reg[{set1, vic1_way}]   <= tag1;
            l1_dirty_reg[{set1, vic1_way}] <= 1'b0;
            l1_age_reg[{set1, vic1_way}]   <= '0;
        end
    end

    // L2 row memory.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            l2_row_mem[row_wa] <= row_wd;
        end
        row_q <= l2_row_mem[row_ra];
    end

    // L1 data memory.
    always_ff @(posedge clk)
    begin
        if (l1d_we)
        begin
            l1_data_mem[l1d_wa] <= l1d_wd;
        end
        l1_q <= l1_data_mem[l1d_ra];
    end

    // L2 data memory.
    always_ff @(posedge clk)
    begin
        if (l2d_we)
        begin
            l2_data_mem[l2d_wa] <= l2d_wd;
        end
        l2_q <= l2_data_mem[l2d_ra];
    end

    // Main memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_wa] <= mem_wd;
        end
        mem_q <= main_mem[mem_ra];
    end

    // Assertions.
    `TLCH_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
    `TLCH_ASSERT_SAME(a_strobe_after_work, res_strobe, $past(busy),
                      "result strobe without work in progress")
    `TLCH_ASSERT_SAME(a_miss_not_bypass, res_strobe && !res.done_res, !bypass_reg,
                      "miss reported in bypass mode")
    `TLCH_ASSERT_SAME(a_miss_no_data, res_strobe && !res.done_res, res.rd_word == '0,
                      "miss result carries data")
    `TLCH_ASSERT_SAME(a_copy_count, (state_reg == ST_COPY1) || (state_reg == ST_COPY2),
                      cnt_reg <= (OFF_W+1)'(LINE_WORDS), "line copy ran past the line")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Two-level cache hierarchy unit testbench
// Drives word accesses over several register settings (penalties, bypass)
// and checks each result beat against a behavioral model of the L1/L2 caches
// and the memory behind them, kept inside this bench.
// ---------------------------------------------------------------------------
module testbench
    import tlch_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int SETTLE_CYCLES  = 40;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    req_t             req = '0;
    logic             res_strobe;
    res_t             res;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_BYPASS;
    logic [PEN_W-1:0] cfg_data = '0;

    typedef struct {
        logic [1:0]       idx;
        logic [PEN_W-1:0] value;
    } reg_write_t;

    req_t       access_q[$];
    reg_write_t reg_write_q[$];
    res_t       expected_res_q[$];
    bit         no_gaps = 1'b0;
    bit         failed = 1'b0;
    int         stall_cycles = 0;

    // Cache model state: index 0 is L1, index 1 is L2.
    int unsigned     line_tag[2][256];
    bit              line_valid[2][256];
    bit              line_dirty[2][256];
    int              line_age[2][256];
    logic [31:0]     line_data[2][2048];
    logic [31:0]     memory_word[MEM_WORDS];
    logic [7:0]      miss_wait[2];
    bit              bypass_mode = 1'b0;
    logic [PEN_W-1:0] l1_penalty = L1_PEN_RESET;
    logic [PEN_W-1:0] l2_penalty = L2_PEN_RESET;

    two_level_cache_hierarchy_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .res_strobe (res_strobe),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int num_sets(int lv);
        return (lv == 0) ? L1_SETS : L2_SETS;
    endfunction

    function automatic int num_ways(int lv);
        return (lv == 0) ? L1_WAYS : L2_WAYS;
    endfunction

    // Slot holding line ln at level lv, or -1 on a miss.
    function automatic int find_slot(int lv, int unsigned ln);
        int unsigned set_idx;
        int          s;
        set_idx = ln % num_sets(lv);
        for (int w = 0; w < num_ways(lv); w++)
        begin
            s = set_idx * num_ways(lv) + w;
            if (line_valid[lv][s] && line_tag[lv][s] == ln / num_sets(lv))
                return s;
        end
        return -1;
    endfunction

    // Make slot s the most recently used way of its set.
    function automatic void touch_slot(int lv, int s);
        int base;
        int cur;
        base = (s / num_ways(lv)) * num_ways(lv);
        cur  = line_age[lv][s];
        for (int w = 0; w < num_ways(lv); w++)
            if (line_valid[lv][base + w] && line_age[lv][base + w] > cur)
                line_age[lv][base + w]--;
        line_age[lv][s] = num_ways(lv) - 1;
    endfunction

    // Lookup guarded by the miss countdown; performs the access on a hit.
    function automatic bit lookup_line(int lv, int unsigned ln, int off, bit wr,
                                       logic [31:0] value, inout logic [31:0] rd,
                                       input logic [7:0] penalty);
        int s;
        if (miss_wait[lv] != 0)
        begin
            miss_wait[lv] = miss_wait[lv] - 8'd1;
            return 1'b0;
        end
        s = find_slot(lv, ln);
        if (s < 0)
        begin
            miss_wait[lv] = penalty - 8'd1;
            return 1'b0;
        end
        touch_slot(lv, s);
        if (wr)
        begin
            line_data[lv][s * LINE_WORDS + off] = value;
            line_dirty[lv][s] = 1'b1;
        end
        else
            rd = line_data[lv][s * LINE_WORDS + off];
        return 1'b1;
    endfunction

    // Install line ln unless present; returns 1 when a valid line was evicted.
    function automatic bit fill_line(int lv, int unsigned ln, logic [31:0] src[LINE_WORDS],
                                     output int unsigned victim_ln, output bit victim_dirty,
                                     output logic [31:0] victim_data[LINE_WORDS]);
        int unsigned set_idx;
        int          s;
        int          t;
        bit          had;
        set_idx = ln % num_sets(lv);
        s = set_idx * num_ways(lv);
        had = 1'b0;
        victim_ln = 0;
        victim_dirty = 1'b0;
        foreach (victim_data[i])
            victim_data[i] = '0;
        if (find_slot(lv, ln) >= 0)
            return 1'b0;
        for (int w = 0; w < num_ways(lv); w++)
        begin
            t = set_idx * num_ways(lv) + w;
            if (!line_valid[lv][t] || line_age[lv][t] == 0)
            begin
                s = t;
                break;
            end
        end
        if (line_valid[lv][s])
        begin
            had = 1'b1;
            victim_ln = line_tag[lv][s] * num_sets(lv) + set_idx;
            victim_dirty = line_dirty[lv][s];
            for (int i = 0; i < LINE_WORDS; i++)
                victim_data[i] = line_data[lv][s * LINE_WORDS + i];
        end
        line_tag[lv][s]   = ln / num_sets(lv);
        line_valid[lv][s] = 1'b1;
        line_dirty[lv][s] = 1'b0;
        line_age[lv][s]   = 0;
        for (int i = 0; i < LINE_WORDS; i++)
            line_data[lv][s * LINE_WORDS + i] = src[i];
        return had;
    endfunction

    // Expected result of one access, updating the cache model.
    function automatic res_t access_result(req_t a);
        res_t        r;
        int unsigned word;
        int unsigned ln;
        int          off;
        bit          wr;
        bit          done;
        logic [31:0] rd;
        logic [31:0] scratch;
        logic [31:0] line_buf[LINE_WORDS];
        logic [31:0] victim_data[LINE_WORDS];
        int unsigned victim_ln;
        bit          victim_dirty;
        int          s;
        word = a.byte_address[ADDR_W-1:2];
        ln   = word / LINE_WORDS;
        off  = word % LINE_WORDS;
        wr   = (a.operation == OP_WRITE);
        done = 1'b1;
        rd   = '0;
        scratch = '0;
        if (a.operation == OP_READ || a.operation == OP_WRITE)
        begin
            if (bypass_mode)
            begin
                if (wr)
                    memory_word[word % MEM_WORDS] = a.store_value;
                else
                    rd = memory_word[word % MEM_WORDS];
            end
            else if (!lookup_line(0, ln, off, wr, a.store_value, rd, l1_penalty))
            begin
                done = 1'b0;
                if (lookup_line(1, ln, off, wr, a.store_value, scratch, l2_penalty))
                begin
                    // L2 hit: copy the line into L1, a dirty L1 victim goes to L2.
                    s = find_slot(1, ln);
                    if (s >= 0)
                    begin
                        for (int i = 0; i < LINE_WORDS; i++)
                            line_buf[i] = line_data[1][s * LINE_WORDS + i];
                        if (fill_line(0, ln, line_buf, victim_ln, victim_dirty, victim_data)
                            && victim_dirty)
                        begin
                            s = find_slot(1, victim_ln);
                            if (s >= 0)
                            begin
                                for (int i = 0; i < LINE_WORDS; i++)
                                    line_data[1][s * LINE_WORDS + i] = victim_data[i];
                                line_dirty[1][s] = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    // L2 miss: refill from memory, evict and write back.
                    for (int i = 0; i < LINE_WORDS; i++)
                        line_buf[i] = memory_word[(ln * LINE_WORDS + i) % MEM_WORDS];
                    if (fill_line(1, ln, line_buf, victim_ln, victim_dirty, victim_data))
                    begin
                        s = find_slot(0, victim_ln);
                        if (s >= 0)
                        begin
                            if (line_dirty[0][s])
                            begin
                                for (int i = 0; i < LINE_WORDS; i++)
                                    victim_data[i] = line_data[0][s * LINE_WORDS + i];
                                victim_dirty = 1'b1;
                            end
                            line_valid[0][s] = 1'b0;
                        end
                        if (victim_dirty)
                            for (int i = 0; i < LINE_WORDS; i++)
                                memory_word[(victim_ln * LINE_WORDS + i) % MEM_WORDS] =
                                    victim_data[i];
                    end
                end
            end
        end
        r.done_res = done;
        r.rd_word  = (done && a.operation == OP_READ) ? rd : '0;
        return r;
    endfunction

    // Request driver: predicts each accepted beat and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_res_q.push_back(access_result(req));
            if (!start || !busy)
            begin
                if (access_q.size() != 0 && (no_gaps || $urandom_range(99) >= 36))
                begin
                    start <= 1'b1;
                    req   <= access_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Register write driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BYPASS: bypass_mode = cfg_data[0];
                    CFG_L1_PEN: l1_penalty = cfg_data;
                    CFG_L2_PEN: l2_penalty = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_q.size() != 0 && $urandom_range(99) >= 36)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= reg_write_q[0].idx;
                    cfg_data  <= reg_write_q[0].value;
                    void'(reg_write_q.pop_front());
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && res_strobe)
        begin
            if (expected_res_q.size() == 0)
            begin
                $display("%0t: unexpected result beat done=%0b data=%h",
                         $realtime, res.done_res, res.rd_word);
                failed = 1'b1;
            end
            else
            begin
                if (res.done_res !== expected_res_q[0].done_res)
                begin
                    $display("%0t: done_res expected %0b actual %0b", $realtime,
                             expected_res_q[0].done_res, res.done_res);
                    failed = 1'b1;
                end
                if (res.rd_word !== expected_res_q[0].rd_word)
                begin
                    $display("%0t: rd_word expected %h actual %h", $realtime,
                             expected_res_q[0].rd_word, res.rd_word);
                    failed = 1'b1;
                end
                void'(expected_res_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Queue one access, repeated the given number of times so that misses are retried.
    task automatic add_access(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] value, int repeats);
        req_t a;
        a.operation    = op;
        a.byte_address = addr;
        a.store_value  = value;
        for (int i = 0; i < repeats; i++)
            access_q.push_back(a);
    endtask

    // Mostly addresses from a few conflicting sets, some anywhere.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned ln;
        if ($urandom_range(99) < 20)
            return ADDR_W'($urandom_range(16383));
        ln = $urandom_range(7) * L2_SETS + $urandom_range(3);
        return ADDR_W'(ln * LINE_WORDS * 4 + $urandom_range(31));
    endfunction

    task automatic add_random(int count, int max_repeats);
        int               added;
        int               r;
        int               reps;
        logic [OP_W-1:0]  op;
        added = 0;
        while (added < count)
        begin
            r = $urandom_range(99);
            if (r < 6)
                op = OP_IDLE;
            else if (r < 9)
                op = OP_RSVD;
            else if (r < 55)
                op = OP_READ;
            else
                op = OP_WRITE;
            reps = $urandom_range(max_repeats, 1);
            add_access(op, pick_address(), $urandom(), reps);
            added += reps;
        end
    endtask

    task automatic set_registers(bit bypass, logic [PEN_W-1:0] pen1, logic [PEN_W-1:0] pen2);
        reg_write_t w;
        w.idx = CFG_BYPASS;
        w.value = PEN_W'(bypass);
        reg_write_q.push_back(w);
        w.idx = CFG_L1_PEN;
        w.value = pen1;
        reg_write_q.push_back(w);
        w.idx = CFG_L2_PEN;
        w.value = pen2;
        reg_write_q.push_back(w);
        wait (reg_write_q.size() == 0 && !cfg_valid);
        @(posedge clk);
    endtask

    // Sender holds off until every expected result has arrived.
    task automatic drain();
        wait (access_q.size() == 0 && !start && expected_res_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        foreach (memory_word[i])
            memory_word[i] = '0;
        for (int lv = 0; lv < 2; lv++)
        begin
            miss_wait[lv] = '0;
            foreach (line_tag[lv][i])
            begin
                line_tag[lv][i]   = 0;
                line_valid[lv][i] = 1'b0;
                line_dirty[lv][i] = 1'b0;
                line_age[lv][i]   = 0;
            end
            foreach (line_data[lv][i])
                line_data[lv][i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed accesses at the reset settings: extremes and retries.
        add_access(OP_IDLE, '0, '0, 1);
        add_access(OP_RSVD, '1, '1, 1);
        add_access(OP_WRITE, 14'h3FFF, 32'hFFFF_FFFF, 14);
        add_access(OP_READ, 14'h3FFF, '0, 3);
        add_access(OP_READ, 14'h0000, 32'hFFFF_FFFF, 14);
        add_access(OP_WRITE, 14'h0004, 32'h0000_0000, 3);
        add_access(OP_READ, 14'h0004, '0, 2);
        drain();

        set_registers(1'b0, 8'd1, 8'd1);
        add_random(500, 4);
        drain();

        // Bypass reads old memory contents behind dirty cache lines.
        set_registers(1'b1, 8'd1, 8'd1);
        add_access(OP_READ, 14'h3FFC, '0, 1);
        add_random(150, 2);
        drain();

        // Zero penalty wraps the countdown to its maximum.
        set_registers(1'b0, 8'd0, 8'd1);
        add_random(40, 3);
        drain();

        set_registers(1'b0, 8'd255, 8'd255);
        add_random(30, 3);
        drain();

        no_gaps = 1'b1;
        set_registers(1'b0, 8'd1, 8'd2);
        add_random(400, 5);
        drain();
        no_gaps = 1'b0;

        set_registers(1'b0, 8'd3, 8'd5);
        add_random(200, 8);
        drain();

        if (failed)
            $display("TEST FAILED");
        else
            $display("TEST PASSED");
        $finish;
    end

endmodule
